[src/jsontok_pkg.sv]
// Shared types, constants and helper functions for the flat JSON object tokenizer.
// Depends on nothing; every other file in src imports it.
package jsontok_pkg;

    // Size limits of the parsed document.
    localparam int MAX_ENTRIES    = 16;
    localparam int KEY_CAPACITY   = 32;
    localparam int VALUE_CAPACITY = 64;

    // Field widths of one input word and one result word.
    localparam int BYTE_W   = 8;
    localparam int ROLE_W   = 3;
    localparam int ENTRY_W  = 4;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 5;

    // Internal counter widths follow from the limits.
    localparam int CAP_MAX = (KEY_CAPACITY > VALUE_CAPACITY) ? KEY_CAPACITY : VALUE_CAPACITY;
    localparam int CCW     = $clog2(CAP_MAX);
    localparam int KCW     = $clog2(MAX_ENTRIES + 1);

    // Result queue geometry.
    localparam int RBUF_DEPTH = 4;
    localparam int RBUF_AW    = $clog2(RBUF_DEPTH);
    localparam int RBUF_CW    = $clog2(RBUF_DEPTH + 1);

    // Characters that steer the parser.
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h7D;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_KEY_CHAR = 3'd0,
        ROLE_VAL_CHAR = 3'd1,
        ROLE_KEY_END  = 3'd2,
        ROLE_VAL_END  = 3'd3,
        ROLE_FINISH   = 3'd4
    } t_role;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_OPEN   = 3'd1,
        ST_TOO_MANY  = 3'd2,
        ST_BAD_KEY   = 3'd3,
        ST_NO_COLON  = 3'd4,
        ST_BAD_VALUE = 3'd5,
        ST_NO_SEP    = 3'd6
    } t_status;

    // Parser phase, one-hot.
    typedef enum logic [10:0] {
        PH_WAIT_OPEN    = 11'b000_0000_0001,
        PH_BEFORE_KEY   = 11'b000_0000_0010,
        PH_IN_KEY       = 11'b000_0000_0100,
        PH_KEY_ESC      = 11'b000_0000_1000,
        PH_AFTER_KEY    = 11'b000_0001_0000,
        PH_BEFORE_VALUE = 11'b000_0010_0000,
        PH_IN_SVALUE    = 11'b000_0100_0000,
        PH_VAL_ESC      = 11'b000_1000_0000,
        PH_IN_BVALUE    = 11'b001_0000_0000,
        PH_AFTER_VALUE  = 11'b010_0000_0000,
        PH_DONE         = 11'b100_0000_0000
    } t_phase;

    // One result word.
    typedef struct packed {
        logic [BYTE_W-1:0]  out_char;
        t_role              role;
        logic [ENTRY_W-1:0] entry_index;
        t_status            status;
        logic [TOTAL_W-1:0] key_total;
        logic               last;
    } t_result;

    // Results pushed by the parser in one cycle (zero, one or two words).
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic f_is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    // Key or value word: character, end marks.
    function automatic t_result f_put(input logic [BYTE_W-1:0] ch, input t_role role,
                                      input logic [KCW-1:0] kc);
        t_result r;
        r.out_char    = ch;
        r.role        = role;
        r.entry_index = ENTRY_W'(kc);
        r.status      = ST_OK;
        r.key_total   = '0;
        r.last        = 1'b0;
        return r;
    endfunction

    // Document finished word.
    function automatic t_result f_finish(input t_status st, input logic [KCW-1:0] kc);
        t_result r;
        r.out_char    = '0;
        r.role        = ROLE_FINISH;
        r.entry_index = '0;
        r.status      = st;
        r.key_total   = TOTAL_W'(kc);
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

[src/jsontok_in_if.sv]
// Input channel of the tokenizer: valid/ready handshake carrying one text byte.
// Depends on jsontok_pkg for field widths.
interface jsontok_in_if import jsontok_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              new_document;

    modport source (output valid, output text_byte, output new_document, input ready);
    modport sink   (input valid, input text_byte, input new_document, output ready);
endinterface

[src/jsontok_out_if.sv]
// Output channel of the tokenizer: valid/ready handshake carrying one result word.
// Depends on jsontok_pkg for field widths.
interface jsontok_out_if import jsontok_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_char;
    logic [ROLE_W-1:0]   role;
    logic [ENTRY_W-1:0]  entry_index;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  key_total;
    logic                last;

    modport source (output valid, output out_char, output role, output entry_index,
                    output status, output key_total, output last, input ready);
    modport sink   (input valid, input out_char, input role, input entry_index,
                    input status, input key_total, input last, output ready);
endinterface

[src/jsontok_parser.sv]
// Parser state machine: phase, character count and key count, plus the
// per-byte next-state and result logic. Depends on jsontok_pkg.
module jsontok_parser import jsontok_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_new_doc,
    output t_push             o_push
);

    t_phase         r_phase, n_phase;
    logic [CCW-1:0] r_cc, n_cc;
    logic [KCW-1:0] r_kc, n_kc;

    t_phase         ph;
    logic [CCW-1:0] cc;
    logic [KCW-1:0] kc;
    logic [KCW-1:0] kc_inc;
    logic           key_room;
    logic           val_room;
    logic           blank;
    logic [1:0]     cnt;
    t_result        res0;
    t_result        res1;

    // A new document clears the state before the byte is looked at.
    always_comb begin
        ph       = i_new_doc ? PH_WAIT_OPEN : r_phase;
        cc       = i_new_doc ? '0 : r_cc;
        kc       = i_new_doc ? '0 : r_kc;
        kc_inc   = (kc < KCW'(MAX_ENTRIES)) ? KCW'(kc + 1'b1) : kc;
        key_room = cc < CCW'(KEY_CAPACITY - 1);
        val_room = cc < CCW'(VALUE_CAPACITY - 1);
        blank    = f_is_blank(i_byte);
    end

    // Next state and up to two result words for this byte.
    always_comb begin
        n_phase = ph;
        n_cc    = cc;
        n_kc    = kc;
        cnt     = 2'd0;
        res0    = '0;
        res1    = '0;
        case (ph)
            PH_WAIT_OPEN: begin
                if (!blank) begin
                    if (i_byte == CH_OPEN) begin
                        n_phase = PH_BEFORE_KEY;
                    end else begin
                        res0 = f_finish(ST_NO_OPEN, kc); cnt = 2'd1; n_phase = PH_DONE;
                    end
                end
            end
            PH_BEFORE_KEY: begin
                if (!blank) begin
                    if (i_byte == CH_CLOSE) begin
                        res0 = f_finish(ST_OK, kc); cnt = 2'd1; n_phase = PH_DONE;
                    end else if (kc >= KCW'(MAX_ENTRIES)) begin
                        res0 = f_finish(ST_TOO_MANY, kc); cnt = 2'd1; n_phase = PH_DONE;
                    end else if (i_byte == CH_QUOTE) begin
                        n_phase = PH_IN_KEY;
                        n_cc    = '0;
                    end else begin
                        res0 = f_finish(ST_BAD_KEY, kc); cnt = 2'd1; n_phase = PH_DONE;
                    end
                end
            end
            PH_IN_KEY: begin
                if (i_byte == CH_NUL) begin
                    res0 = f_finish(ST_BAD_KEY, kc); cnt = 2'd1; n_phase = PH_DONE;
                end else if (i_byte == CH_BSLASH) begin
                    n_phase = PH_KEY_ESC;
                end else if (i_byte == CH_QUOTE) begin
                    res0 = f_put(CH_NUL, ROLE_KEY_END, kc); cnt = 2'd1;
                    n_phase = PH_AFTER_KEY;
                end else if (key_room) begin
                    res0 = f_put(i_byte, ROLE_KEY_CHAR, kc); cnt = 2'd1;
                    n_cc = CCW'(cc + 1'b1);
                end
            end
            PH_KEY_ESC: begin
                if (i_byte == CH_NUL) begin
                    // A dangling backslash is kept as a literal, then the key fails.
                    n_phase = PH_DONE;
                    if (key_room) begin
                        res0 = f_put(CH_BSLASH, ROLE_KEY_CHAR, kc);
                        res1 = f_finish(ST_BAD_KEY, kc);
                        cnt  = 2'd2;
                        n_cc = CCW'(cc + 1'b1);
                    end else begin
                        res0 = f_finish(ST_BAD_KEY, kc); cnt = 2'd1;
                    end
                end else begin
                    n_phase = PH_IN_KEY;
                    if (key_room) begin
                        res0 = f_put(i_byte, ROLE_KEY_CHAR, kc); cnt = 2'd1;
                        n_cc = CCW'(cc + 1'b1);
                    end
                end
            end
            PH_AFTER_KEY: begin
                if (!blank) begin
                    if (i_byte == CH_COLON) begin
                        n_phase = PH_BEFORE_VALUE;
                    end else begin
                        res0 = f_finish(ST_NO_COLON, kc); cnt = 2'd1; n_phase = PH_DONE;
                    end
                end
            end
            PH_BEFORE_VALUE: begin
                if (!blank) begin
                    n_cc = '0;
                    if (i_byte == CH_QUOTE) begin
                        n_phase = PH_IN_SVALUE;
                    end else if (i_byte == CH_COMMA) begin
                        res0 = f_put(CH_NUL, ROLE_VAL_END, kc); cnt = 2'd1;
                        n_kc = kc_inc; n_phase = PH_BEFORE_KEY;
                    end else if (i_byte == CH_CLOSE || i_byte == CH_NUL) begin
                        res0 = f_put(CH_NUL, ROLE_VAL_END, kc);
                        res1 = f_finish((i_byte == CH_CLOSE) ? ST_OK : ST_NO_SEP, kc_inc);
                        cnt  = 2'd2;
                        n_kc = kc_inc; n_phase = PH_DONE;
                    end else begin
                        // First character of a bare value always fits.
                        res0 = f_put(i_byte, ROLE_VAL_CHAR, kc); cnt = 2'd1;
                        n_cc = CCW'(1); n_phase = PH_IN_BVALUE;
                    end
                end
            end
            PH_IN_SVALUE: begin
                if (i_byte == CH_NUL) begin
                    res0 = f_finish(ST_BAD_VALUE, kc); cnt = 2'd1; n_phase = PH_DONE;
                end else if (i_byte == CH_BSLASH) begin
                    n_phase = PH_VAL_ESC;
                end else if (i_byte == CH_QUOTE) begin
                    res0 = f_put(CH_NUL, ROLE_VAL_END, kc); cnt = 2'd1;
                    n_kc = kc_inc; n_phase = PH_AFTER_VALUE;
                end else if (val_room) begin
                    res0 = f_put(i_byte, ROLE_VAL_CHAR, kc); cnt = 2'd1;
                    n_cc = CCW'(cc + 1'b1);
                end
            end
            PH_VAL_ESC: begin
                if (i_byte == CH_NUL) begin
                    n_phase = PH_DONE;
                    if (val_room) begin
                        res0 = f_put(CH_BSLASH, ROLE_VAL_CHAR, kc);
                        res1 = f_finish(ST_BAD_VALUE, kc);
                        cnt  = 2'd2;
                        n_cc = CCW'(cc + 1'b1);
                    end else begin
                        res0 = f_finish(ST_BAD_VALUE, kc); cnt = 2'd1;
                    end
                end else begin
                    n_phase = PH_IN_SVALUE;
                    if (val_room) begin
                        res0 = f_put(i_byte, ROLE_VAL_CHAR, kc); cnt = 2'd1;
                        n_cc = CCW'(cc + 1'b1);
                    end
                end
            end
            PH_IN_BVALUE: begin
                if (blank || i_byte == CH_COMMA) begin
                    res0 = f_put(CH_NUL, ROLE_VAL_END, kc); cnt = 2'd1;
                    n_kc = kc_inc;
                    n_phase = blank ? PH_AFTER_VALUE : PH_BEFORE_KEY;
                end else if (i_byte == CH_CLOSE || i_byte == CH_NUL) begin
                    res0 = f_put(CH_NUL, ROLE_VAL_END, kc);
                    res1 = f_finish((i_byte == CH_CLOSE) ? ST_OK : ST_NO_SEP, kc_inc);
                    cnt  = 2'd2;
                    n_kc = kc_inc; n_phase = PH_DONE;
                end else if (val_room) begin
                    res0 = f_put(i_byte, ROLE_VAL_CHAR, kc); cnt = 2'd1;
                    n_cc = CCW'(cc + 1'b1);
                end
            end
            PH_AFTER_VALUE: begin
                if (!blank) begin
                    if (i_byte == CH_COMMA) begin
                        n_phase = PH_BEFORE_KEY;
                    end else begin
                        res0 = f_finish((i_byte == CH_CLOSE) ? ST_OK : ST_NO_SEP, kc);
                        cnt = 2'd1; n_phase = PH_DONE;
                    end
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // Mark the final word of this byte.
        if (cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    assign o_push.cnt = i_accept ? cnt : 2'd0;
    assign o_push.r0  = res0;
    assign o_push.r1  = res1;

    // Parser state advances only on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_OPEN;
            r_cc    <= '0;
            r_kc    <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cc    <= n_cc;
            r_kc    <= n_kc;
        end
    end

    // The key count saturates at the entry limit.
    a_kc_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kc <= KCW'(MAX_ENTRIES))
        else $error("key count beyond entry limit");

    // Two words per byte only ever end in a finish word.
    a_pair_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.cnt == 2'd2 |-> (o_push.r1.role == ROLE_FINISH &&
                                o_push.r0.role != ROLE_FINISH))
        else $error("two-word push not closed by finish");

    // A finish word leaves the parser in the done phase.
    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt != 2'd0 &&
         (o_push.r0.role == ROLE_FINISH || o_push.r1.role == ROLE_FINISH))
        |=> r_phase == PH_DONE)
        else $error("finish word without done phase");

endmodule

[src/jsontok_rbuf.sv]
// Result queue: takes up to two result words per cycle and hands out one per
// cycle while the output is ready. Depends on jsontok_pkg, jsontok_out_if.
module jsontok_rbuf import jsontok_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_push         i_push,
    output logic          o_room,
    jsontok_out_if.source o_out
);

    t_result              r_mem [RBUF_DEPTH];
    logic [RBUF_AW-1:0]   r_wr_ptr;
    logic [RBUF_AW-1:0]   r_rd_ptr;
    logic [RBUF_CW-1:0]   r_count;
    logic [RBUF_AW-1:0]   wr_ptr1;
    logic                 pop;
    t_result              head;

    assign wr_ptr1 = RBUF_AW'(r_wr_ptr + 1'b1);
    assign pop     = o_out.valid && o_out.ready;
    assign o_room  = r_count <= RBUF_CW'(RBUF_DEPTH - 2);

    // Store incoming words.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= RBUF_AW'(r_wr_ptr + i_push.cnt);
            if (pop) begin
                r_rd_ptr <= RBUF_AW'(r_rd_ptr + 1'b1);
            end
            r_count <= RBUF_CW'(r_count + i_push.cnt - RBUF_CW'(pop));
        end
    end

    // Head of the queue drives the output word.
    assign head              = r_mem[r_rd_ptr];
    assign o_out.valid       = r_count != '0;
    assign o_out.out_char    = head.out_char;
    assign o_out.role        = head.role;
    assign o_out.entry_index = head.entry_index;
    assign o_out.status      = head.status;
    assign o_out.key_total   = head.key_total;
    assign o_out.last        = head.last;

    // The fill count never passes the depth.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RBUF_CW'(RBUF_DEPTH))
        else $error("result queue overfilled");

    // A push always finds room for all of its words.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) + int'(i_push.cnt) <= RBUF_DEPTH)
        else $error("push into a queue without room");

    // A pop with no push shrinks the queue by one word.
    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.cnt == 2'd0) |=> r_count == RBUF_CW'($past(r_count) - 1'b1))
        else $error("fill count off after pop");

endmodule

[src/flat_json_object_tokenizer_unit.sv]
// Flat JSON object tokenizer, top level. The result words of an accepted byte are
// registered in the result queue and reach the output behind any earlier words.
// Throughput: one byte per cycle; result words leave the queue one at a time, and the
// input stalls while the four-word result queue has fewer than two free slots.
// Synchronous active-low reset clears phase, counts and the result queue.
// Depends on jsontok_pkg, jsontok_in_if, jsontok_out_if, jsontok_parser, jsontok_rbuf.
module flat_json_object_tokenizer_unit import jsontok_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jsontok_in_if.sink    i_in,
    jsontok_out_if.source o_out
);

    logic  room;
    logic  accept;
    t_push push;

    // Take a byte whenever the queue can hold both of its possible words.
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    jsontok_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_in.text_byte),
        .i_new_doc (i_in.new_document),
        .o_push    (push)
    );

    jsontok_rbuf u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule
